### src/irm_pkg.sv
// ----------------------------------------------------------------------------
// irm_pkg: shared types and constants for the interval range map
// Field widths, status and command codes, and the cell control group.
// ----------------------------------------------------------------------------
package irm_pkg;

   localparam int KEY_W    = 32;
   localparam int VAL_W    = 8;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 6;
   localparam int CSR_AW   = 3;

   // commands carried in tuser
   localparam logic CMD_ASSIGN = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // register word index (paddr bit 2)
   localparam logic REG_DEFAULT = 1'b0;
   localparam logic [VAL_W-1:0] DEFAULT_RESET = 8'd65;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [VAL_W-1:0] val_type;

   // per-cell control: take the neighbor's entry, or load in parallel
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

### src/irm_cell.sv
// ----------------------------------------------------------------------------
// irm_cell: one breakpoint slot of the table chain
// Holds a key and value; takes its neighbor's entry or a parallel load.
// ----------------------------------------------------------------------------
module irm_cell (
   input  logic                clock,
   input  irm_pkg::cell_ctl_type ctl,
   input  irm_pkg::key_type    shift_key,
   input  irm_pkg::val_type    shift_val,
   input  irm_pkg::key_type    load_key,
   input  irm_pkg::val_type    load_val,
   output irm_pkg::key_type    key_out,
   output irm_pkg::val_type    val_out
);
   import irm_pkg::*;

   key_type key_ff, key_in;
   val_type val_ff, val_in;

   // neighbor shift wins over parallel load (never both)
   always_comb begin
      key_in = key_ff;
      val_in = val_ff;
      if (ctl.shift) begin
         key_in = shift_key;
         val_in = shift_val;
      end else if (ctl.load) begin
         key_in = load_key;
         val_in = load_val;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      val_ff <= val_in;
   end

   assign key_out = key_ff;
   assign val_out = val_ff;

endmodule

### src/interval_range_map.sv
// ----------------------------------------------------------------------------
// interval_range_map: sorted breakpoint table with range assign and lookup
// Two rows of cells: the live table rotates as a ring past a compare unit,
// and a build row collects the rebuilt table which is then loaded back.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | content
//  req      | in  | tvalid/tready       | tuser cmd, tdata keys and value
//  rsp      | out | tvalid/tready       | tdata read_value, status, entries_used
//  csr      | in  | psel/penable, APB   | default_value at byte address 0
//
// Lookup: one rotation of the ring, check, result.
// Assign: scan rotation, check, rebuild rotation with the two inserts,
// close, load, result; a refused assign ends after the check and an empty
// range goes straight to the result.
// The ring walks one cell a cycle by a single compare unit, pausing for inserts.
// Reset clears the count, sequencer and output valid, and restores the default.
// A waiting result holds the sequencer in its last state; a new word is
// taken whenever the sequencer is idle.
module interval_range_map #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [71:0]                  req_tdata,  // key_lo, key_hi, new_value
   input  logic                         req_tuser,  // cmd
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [15:0]                  rsp_tdata,  // read_value, status, entries_used
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [irm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import irm_pkg::*;

   localparam int D  = TABLE_DEPTH;
   localparam int CW = $clog2(D + 1);
   localparam int IW = $clog2(D);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_BUILD = 3'd3;
   localparam logic [2:0] S_COPY  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] below_ff, below_in, above_ff, above_in;
   logic [CW:0]   n_ff, n_in;
   logic [1:0]    phase_ff, phase_in;
   logic          cmd_ff, cmd_in, fprev_ff, fprev_in, fend_ff, fend_in;
   key_type       lo_ff, lo_in, hi_ff, hi_in;
   val_type       nv_ff, nv_in, prev_ff, prev_in, end_ff, end_in;
   val_type       default_ff, default_in;
   val_type       res_read_ff, res_read_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;

   key_type       a_key [D];
   val_type       a_val [D];
   key_type       b_key [D];
   val_type       b_val [D];
   cell_ctl_type  a_ctl, b_ctl;
   key_type       push_key;
   val_type       push_val;

   logic [IW-1:0] head_idx;
   logic          head_valid, in_scan, csr_wr, out_free, accept;
   key_type       head_key;
   val_type       head_val, pv, ev;
   logic [CW:0]   n_sum;

   // live ring: cell i takes cell i-1, cell 0 takes the head
   // build row: cell 0 takes the pushed entry, cell i takes cell i-1
   for (genvar i = 0; i < D; i++) begin : g_cells
      irm_cell u_live (
         .clock     (clock),
         .ctl       (a_ctl),
         .shift_key (a_key[(i + D - 1) % D]),
         .shift_val (a_val[(i + D - 1) % D]),
         .load_key  (b_key[i]),
         .load_val  (b_val[i]),
         .key_out   (a_key[i]),
         .val_out   (a_val[i])
      );
      if (i == 0) begin : g_first
         irm_cell u_build (
            .clock     (clock),
            .ctl       (b_ctl),
            .shift_key (push_key),
            .shift_val (push_val),
            .load_key  (push_key),
            .load_val  (push_val),
            .key_out   (b_key[i]),
            .val_out   (b_val[i])
         );
      end else begin : g_rest
         irm_cell u_build (
            .clock     (clock),
            .ctl       (b_ctl),
            .shift_key (b_key[i-1]),
            .shift_val (b_val[i-1]),
            .load_key  (b_key[i-1]),
            .load_val  (b_val[i-1]),
            .key_out   (b_key[i]),
            .val_out   (b_val[i])
         );
      end
   end

   // head of the ring holds entry D-1-step
   assign head_key   = a_key[D-1];
   assign head_val   = a_val[D-1];
   assign head_idx   = IW'(D - 1) - step_ff[IW-1:0];
   assign in_scan    = step_ff < CW'(D);
   assign head_valid = in_scan && (CW'(head_idx) < count_ff);

   assign pv = fprev_ff ? prev_ff : default_ff;
   assign ev = fend_ff ? end_ff : default_ff;
   assign n_sum = (CW+1)'(below_ff) + (CW+1)'(above_ff)
                + (CW+1)'(nv_ff != pv) + (CW+1)'(ev != nv_ff);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // sequencer
   always_comb begin
      state_in = state_ff;  step_in = step_ff;   count_in = count_ff;
      below_in = below_ff;  above_in = above_ff; n_in = n_ff;
      phase_in = phase_ff;  cmd_in = cmd_ff;     fprev_in = fprev_ff;
      fend_in = fend_ff;    lo_in = lo_ff;       hi_in = hi_ff;
      nv_in = nv_ff;        prev_in = prev_ff;   end_in = end_ff;
      res_read_in = res_read_ff; res_st_in = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      a_ctl = '0;  b_ctl = '0;
      push_key = head_key;  push_val = head_val;
      default_in = default_ff;
      if (csr_wr && csr_paddr[2] == REG_DEFAULT) default_in = csr_pwdata[VAL_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_tuser;
               lo_in  = req_tdata[31:0];
               hi_in  = (req_tuser == CMD_LOOKUP) ? req_tdata[31:0] : req_tdata[63:32];
               nv_in  = req_tdata[71:64];
               step_in = '0;  below_in = '0;  above_in = '0;
               fprev_in = 1'b0;  fend_in = 1'b0;
               res_read_in = '0;  res_st_in = ST_OK;
               if (req_tuser == CMD_ASSIGN &&
                   $signed(req_tdata[63:32]) <= $signed(req_tdata[31:0])) begin
                  res_st_in = ST_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // first hits from the top are the last entries below each key
            a_ctl.shift = 1'b1;
            step_in = step_ff + 1'b1;
            if (head_valid) begin
               if ($signed(head_key) < $signed(lo_ff)) begin
                  below_in = below_ff + 1'b1;
                  if (!fprev_ff) begin
                     fprev_in = 1'b1;  prev_in = head_val;
                  end
               end
               if ($signed(head_key) <= $signed(hi_ff)) begin
                  if (!fend_ff) begin
                     fend_in = 1'b1;  end_in = head_val;
                  end
               end else begin
                  above_in = above_ff + 1'b1;
               end
            end
            if (step_ff == CW'(D - 1)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            step_in = '0;  phase_in = '0;  n_in = n_sum;
            prev_in = pv;  end_in = ev;
            fprev_in = 1'b1;  fend_in = 1'b1;
            if (cmd_ff == CMD_LOOKUP) begin
               res_read_in = ev;
               state_in = S_DONE;
            end else if (n_sum > (CW+1)'(D)) begin
               res_st_in = ST_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_BUILD;
            end
         end
         S_BUILD: begin
            // descending walk: entries above hi, inserts, entries below lo
            if (head_valid && $signed(head_key) > $signed(hi_ff)) begin
               b_ctl.shift = 1'b1;  a_ctl.shift = 1'b1;
               step_in = step_ff + 1'b1;
            end else if (in_scan && !head_valid) begin
               a_ctl.shift = 1'b1;
               step_in = step_ff + 1'b1;
            end else if (phase_ff != 2'd2) begin
               phase_in = phase_ff + 1'b1;
               if (phase_ff == 2'd0) begin
                  push_key = hi_ff;  push_val = end_ff;
                  b_ctl.shift = (end_ff != nv_ff);
               end else begin
                  push_key = lo_ff;  push_val = nv_ff;
                  b_ctl.shift = (nv_ff != prev_ff);
               end
            end else if (in_scan) begin
               b_ctl.shift = ($signed(head_key) < $signed(lo_ff));
               a_ctl.shift = 1'b1;
               step_in = step_ff + 1'b1;
            end else begin
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            a_ctl.load = 1'b1;
            count_in = n_ff[CW-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {USED_W'(count_ff), res_st_ff, res_read_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         default_ff   <= DEFAULT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         default_ff   <= default_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;   below_ff <= below_in;  above_ff <= above_in;
      n_ff <= n_in;         phase_ff <= phase_in;  cmd_ff <= cmd_in;
      fprev_ff <= fprev_in; fend_ff <= fend_in;    lo_ff <= lo_in;
      hi_ff <= hi_in;       nv_ff <= nv_in;        prev_ff <= prev_in;
      end_ff <= end_in;     res_read_ff <= res_read_in;
      res_st_ff <= res_st_in; rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_DEFAULT) ? 32'(default_ff) : 32'd0;

`ifndef SYNTH
   // table never holds more than its depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(D)) else $error("entry count above depth");

   // an accepted word always starts work
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE) else $error("accepted word dropped");

   // load takes the checked size
   a_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |=> count_ff == $past(n_ff[CW-1:0]))
      else $error("count not loaded");

   // a result is only issued from the final state
   a_issue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_DONE)
      else $error("result issued out of sequence");
`endif

endmodule
